@@ sv/array_list_insert_delete_search_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the array list block.
// Each macro checks an implication on the rising edge of clk, outside reset.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_INSERT_DELETE_SEARCH_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_SEARCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ALIST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ALIST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/alist_pkg.sv @@
// ----------------------------------------------------------------------------
// alist_pkg
// Types, sizes and codes shared by the array list block and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package alist_pkg;

	localparam int DEPTH = 32;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 6;
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_SEARCH = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_POS_ZERO  = 3'd1,
		STAT_BEYOND    = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_EMPTY     = 3'd4,
		STAT_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PUT,
		ST_SCAN,
		ST_FETCH0,
		ST_FETCH1,
		ST_FETCH2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [WORD_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]               status;
		logic [POS_W-1:0]         found_position;
		logic [POS_W-1:0]         count;
		logic signed [WORD_W-1:0] first_value;
		logic signed [WORD_W-1:0] last_value;
	} rsp_t;

endpackage

`default_nettype wire

@@ sv/alist_ram.sv @@
// ----------------------------------------------------------------------------
// alist_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module alist_ram #(
	parameter int W = 32,
	parameter int D = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/array_list_insert_delete_search.sv @@
// ----------------------------------------------------------------------------
// array_list_insert_delete_search
// Ordered list of signed words held in one RAM, with clear, insert, delete
// and search requests. Every response carries the count and end entries.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall alist_pkg::req_t
// rsp      out        rsp_valid/rsp_stall alist_pkg::rsp_t
//
// One request is worked at a time; the RAM's single read port sets the pace.
// Clear and rejected requests go straight to the response; insert shifts
// entries up, delete shifts them down and rereads the ends, search scans.
// Reset clears control state; entries are never read before being written.
// A stalled response is held while the next request is accepted and worked.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_list_insert_delete_search_macros.svh"

module array_list_insert_delete_search (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire alist_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output alist_pkg::rsp_t      rsp
);

	localparam int AW    = alist_pkg::AW;
	localparam int CNT_W = alist_pkg::CNT_W;
	localparam int CMP_W = alist_pkg::CMP_W;
	localparam int POS_W = alist_pkg::POS_W;
	localparam int WW    = alist_pkg::WORD_W;

	alist_pkg::state_t  state_q, state_d;
	alist_pkg::status_t status_q, status_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [WW-1:0]      first_q, first_d, last_q, last_d, word_q, word_d;
	logic [AW-1:0]      idx_q, idx_d, stop_q, stop_d;
	logic [CNT_W-1:0]   scan_q, scan_d, found_q, found_d;
	logic               ins_q, ins_d;
	logic               sv_s1, sv_d;
	logic [CNT_W-1:0]   sidx_s1, sidx_d;
	logic               rsp_valid_d;
	alist_pkg::rsp_t    rsp_d;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [WW-1:0]      ram_wdata, ram_rdata;

	logic [CMP_W-1:0]   pos_x, cnt_x;
	logic               issuing;

	alist_ram #(
		.W(WW),
		.D(alist_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_stall = (state_q != alist_pkg::ST_IDLE);
	assign pos_x     = CMP_W'(req.position);
	assign cnt_x     = CMP_W'(cnt_q);
	assign issuing   = (scan_q < cnt_q);

	always_comb begin
		state_d     = state_q;
		status_d    = status_q;
		cnt_d       = cnt_q;
		first_d     = first_q;
		last_d      = last_q;
		word_d      = word_q;
		idx_d       = idx_q;
		stop_d      = stop_q;
		scan_d      = scan_q;
		found_d     = found_q;
		ins_d       = ins_q;
		sv_d        = 1'b0;
		sidx_d      = sidx_s1;
		rsp_valid_d = rsp_valid && rsp_stall;
		rsp_d       = rsp;
		ram_we      = 1'b0;
		ram_waddr   = idx_q;
		ram_wdata   = ram_rdata;
		ram_raddr   = idx_q;

		case (state_q)
			alist_pkg::ST_IDLE: begin
				if (req_valid) begin
					word_d   = req.value;
					status_d = alist_pkg::STAT_OK;
					found_d  = '0;
					state_d  = alist_pkg::ST_DONE;
					case (alist_pkg::kind_t'(req.kind))
						alist_pkg::KIND_CLEAR: begin
							cnt_d = '0;
						end
						alist_pkg::KIND_INSERT: begin
							if (cnt_x >= CMP_W'(alist_pkg::DEPTH)) begin
								status_d = alist_pkg::STAT_FULL;
							end else if (pos_x == '0) begin
								status_d = alist_pkg::STAT_POS_ZERO;
							end else if (pos_x > cnt_x + CMP_W'(1)) begin
								status_d = alist_pkg::STAT_BEYOND;
							end else begin
								ins_d  = 1'b1;
								stop_d = AW'(pos_x - CMP_W'(1));
								idx_d  = AW'(cnt_x - CMP_W'(1));
								if (pos_x == CMP_W'(1)) begin
									first_d = req.value;
								end
								if (pos_x == cnt_x + CMP_W'(1)) begin
									last_d  = req.value;
									state_d = alist_pkg::ST_PUT;
								end else begin
									state_d = alist_pkg::ST_SHIFT_RD;
								end
							end
						end
						alist_pkg::KIND_DELETE: begin
							if (cnt_q == '0) begin
								status_d = alist_pkg::STAT_EMPTY;
							end else if (pos_x == '0) begin
								status_d = alist_pkg::STAT_POS_ZERO;
							end else if (pos_x > cnt_x) begin
								status_d = alist_pkg::STAT_BEYOND;
							end else begin
								ins_d  = 1'b0;
								cnt_d  = cnt_q - CNT_W'(1);
								idx_d  = AW'(pos_x);
								stop_d = AW'(cnt_x - CMP_W'(1));
								if (pos_x != cnt_x) begin
									state_d = alist_pkg::ST_SHIFT_RD;
								end else if (cnt_q != CNT_W'(1)) begin
									state_d = alist_pkg::ST_FETCH0;
								end
							end
						end
						alist_pkg::KIND_SEARCH: begin
							scan_d = '0;
							if (cnt_q == '0) begin
								status_d = alist_pkg::STAT_NOT_FOUND;
							end else begin
								state_d = alist_pkg::ST_SCAN;
							end
						end
						default: begin
							state_d = alist_pkg::ST_DONE;
						end
					endcase
				end
			end
			alist_pkg::ST_SHIFT_RD: begin
				ram_raddr = idx_q;
				state_d   = alist_pkg::ST_SHIFT_WR;
			end
			alist_pkg::ST_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				ram_waddr = ins_q ? (idx_q + AW'(1)) : (idx_q - AW'(1));
				if (idx_q == stop_q) begin
					state_d = ins_q ? alist_pkg::ST_PUT : alist_pkg::ST_FETCH0;
				end else begin
					idx_d   = ins_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
					state_d = alist_pkg::ST_SHIFT_RD;
				end
			end
			alist_pkg::ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = stop_q;
				ram_wdata = word_q;
				cnt_d     = cnt_q + CNT_W'(1);
				state_d   = alist_pkg::ST_DONE;
			end
			alist_pkg::ST_SCAN: begin
				ram_raddr = AW'(scan_q);
				sv_d      = issuing;
				sidx_d    = scan_q;
				if (issuing) begin
					scan_d = scan_q + CNT_W'(1);
				end
				if (sv_s1 && (ram_rdata == word_q)) begin
					found_d = sidx_s1 + CNT_W'(1);
					sv_d    = 1'b0;
					state_d = alist_pkg::ST_DONE;
				end else if (sv_s1 && (sidx_s1 == cnt_q - CNT_W'(1))) begin
					status_d = alist_pkg::STAT_NOT_FOUND;
					sv_d     = 1'b0;
					state_d  = alist_pkg::ST_DONE;
				end
			end
			alist_pkg::ST_FETCH0: begin
				ram_raddr = '0;
				state_d   = alist_pkg::ST_FETCH1;
			end
			alist_pkg::ST_FETCH1: begin
				ram_raddr = AW'(cnt_q - CNT_W'(1));
				first_d   = ram_rdata;
				state_d   = alist_pkg::ST_FETCH2;
			end
			alist_pkg::ST_FETCH2: begin
				last_d  = ram_rdata;
				state_d = alist_pkg::ST_DONE;
			end
			alist_pkg::ST_DONE: begin
				if (!rsp_valid || !rsp_stall) begin
					rsp_valid_d          = 1'b1;
					rsp_d.status         = status_q;
					rsp_d.found_position = POS_W'(found_q);
					rsp_d.count          = POS_W'(cnt_q);
					rsp_d.first_value    = (cnt_q == '0) ? '0 : first_q;
					rsp_d.last_value     = (cnt_q == '0) ? '0 : last_q;
					state_d              = alist_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = alist_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= alist_pkg::ST_IDLE;
			cnt_q     <= '0;
			sv_s1     <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			sv_s1     <= sv_d;
			rsp_valid <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		first_q  <= first_d;
		last_q   <= last_d;
		word_q   <= word_d;
		idx_q    <= idx_d;
		stop_q   <= stop_d;
		scan_q   <= scan_d;
		found_q  <= found_d;
		ins_q    <= ins_d;
		sidx_s1  <= sidx_d;
		rsp      <= rsp_d;
	end

	`ALIST_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(alist_pkg::DEPTH), "count above depth")
	`ALIST_ASSERT_NEXT(a_put_grows, state_q == alist_pkg::ST_PUT, cnt_q == $past(cnt_q) + CNT_W'(1), "insert did not grow count")
	`ALIST_ASSERT_NOW(a_scan_tag, sv_s1, sidx_s1 < cnt_q, "scan read beyond count")

endmodule

`default_nettype wire

@@ tb/sv/array_list_insert_delete_search_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_search_tb
// Drives clear, insert, delete and search requests into the list block with
// random gaps on the request side and random stalls on the response side.
// A shadow copy of the list predicts every response, and a checker compares
// each accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module array_list_insert_delete_search_tb;

	import alist_pkg::*;

	localparam int RANDOM_REQUESTS = 340;
	localparam int DRAIN_CYCLES    = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic signed [WORD_W-1:0] list_entries [0:DEPTH-1];
	int list_count = 0;
	rsp_t expected_rsp [$];
	int errors = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	logic signed [WORD_W-1:0] value_pool [0:3];

	array_list_insert_delete_search i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic rsp_t apply_request(req_t r);
		rsp_t e;
		int p;
		int i;
		e = '0;
		p = r.position;
		case (kind_t'(r.kind))
			KIND_CLEAR: begin
				list_count = 0;
			end
			KIND_INSERT: begin
				if (list_count >= DEPTH) begin
					e.status = STAT_FULL;
				end else if (p == 0) begin
					e.status = STAT_POS_ZERO;
				end else if (p > list_count + 1) begin
					e.status = STAT_BEYOND;
				end else begin
					for (i = list_count; i >= p; i--)
						list_entries[i] = list_entries[i-1];
					list_entries[p-1] = r.value;
					list_count++;
				end
			end
			KIND_DELETE: begin
				if (list_count == 0) begin
					e.status = STAT_EMPTY;
				end else if (p == 0) begin
					e.status = STAT_POS_ZERO;
				end else if (p > list_count) begin
					e.status = STAT_BEYOND;
				end else begin
					for (i = p - 1; i + 1 < list_count; i++)
						list_entries[i] = list_entries[i+1];
					list_count--;
				end
			end
			default: begin
				e.status = STAT_NOT_FOUND;
				for (i = 0; i < list_count; i++) begin
					if (e.status == STAT_NOT_FOUND && list_entries[i] == r.value) begin
						e.status = STAT_OK;
						e.found_position = POS_W'(i + 1);
					end
				end
			end
		endcase
		e.count = POS_W'(list_count);
		if (list_count != 0) begin
			e.first_value = list_entries[0];
			e.last_value = list_entries[list_count-1];
		end
		return e;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("ERROR %t: %s got %0d expected %0d", $realtime, what, got, exp);
		errors++;
	endtask

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("response with no request outstanding, status", rsp.status, 0);
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status)
					report_mismatch("status", rsp.status, e.status);
				if (rsp.found_position !== e.found_position)
					report_mismatch("found_position", rsp.found_position, e.found_position);
				if (rsp.count !== e.count)
					report_mismatch("count", rsp.count, e.count);
				if (rsp.first_value !== e.first_value)
					report_mismatch("first_value", rsp.first_value, e.first_value);
				if (rsp.last_value !== e.last_value)
					report_mismatch("last_value", rsp.last_value, e.last_value);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(10, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 1) == 0);
			default: rsp_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	task automatic send_request(input kind_t k, input logic signed [WORD_W-1:0] v,
			input int p);
		req_t r;
		int gap;
		r.kind = k;
		r.value = v;
		r.position = POS_W'(p);
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		expected_rsp.push_back(apply_request(r));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic signed [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3, 4: return value_pool[$urandom_range(0, 3)];
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_list();
		send_request(KIND_CLEAR, 0, 0);
		send_request(KIND_SEARCH, 0, 0);
		send_request(KIND_DELETE, 0, 1);
		send_request(KIND_DELETE, 0, 0);
		send_request(KIND_INSERT, 5, 0);
		send_request(KIND_INSERT, 5, 2);
	endtask

	task automatic test_insert_edges();
		send_request(KIND_INSERT, 32'sh7fffffff, 1);
		send_request(KIND_INSERT, 32'sh80000000, 1);
		send_request(KIND_INSERT, -1, 3);
		send_request(KIND_INSERT, 0, 2);
		send_request(KIND_INSERT, 7, 6);
	endtask

	task automatic test_search();
		send_request(KIND_SEARCH, 32'sh7fffffff, 0);
		send_request(KIND_SEARCH, -1, 0);
		send_request(KIND_SEARCH, 12345, 0);
		send_request(KIND_INSERT, -1, 1);
		send_request(KIND_SEARCH, -1, 0);
	endtask

	task automatic test_delete();
		send_request(KIND_DELETE, 0, 0);
		send_request(KIND_DELETE, 0, 6);
		send_request(KIND_DELETE, 0, 5);
		send_request(KIND_DELETE, 0, 1);
		send_request(KIND_DELETE, 0, 2);
		send_request(KIND_CLEAR, 0, 0);
		send_request(KIND_SEARCH, -1, 0);
	endtask

	task automatic test_full_list();
		send_request(KIND_CLEAR, 0, 0);
		while (list_count < DEPTH)
			send_request(KIND_INSERT, pick_value(), $urandom_range(1, list_count + 1));
		send_request(KIND_INSERT, 1, 0);
		send_request(KIND_INSERT, 1, DEPTH);
		send_request(KIND_SEARCH, list_entries[DEPTH-1], 0);
		send_request(KIND_DELETE, 0, DEPTH);
		send_request(KIND_INSERT, 32'sh55555555, DEPTH);
		send_request(KIND_DELETE, 0, 1);
		send_request(KIND_INSERT, 32'shaaaaaaaa, 1);
	endtask

	task automatic test_random();
		int n;
		int roll;
		bit growing;
		growing = 1'b1;
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			if (list_count == DEPTH || $urandom_range(0, 39) == 0)
				growing = 1'b0;
			else if (list_count == 0)
				growing = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				send_request(KIND_CLEAR, pick_value(), $urandom_range(0, DEPTH));
			end else if (roll < 10) begin
				send_request(kind_t'($urandom_range(1, 2)), pick_value(),
					($urandom_range(0, 1) == 0) ? 0 : $urandom_range(list_count, DEPTH));
			end else if (roll < 35) begin
				if (list_count != 0 && $urandom_range(0, 1) == 0)
					send_request(KIND_SEARCH, list_entries[$urandom_range(0, list_count - 1)],
						$urandom_range(0, DEPTH));
				else
					send_request(KIND_SEARCH, pick_value(), $urandom_range(0, DEPTH));
			end else if (growing ? (roll < 85) : (roll < 50)) begin
				send_request(KIND_INSERT, pick_value(),
					(list_count < DEPTH) ? $urandom_range(1, list_count + 1) : $urandom_range(0, DEPTH));
			end else begin
				send_request(KIND_DELETE, pick_value(),
					(list_count > 0) ? $urandom_range(1, list_count) : $urandom_range(0, DEPTH));
			end
		end
	endtask

	initial begin
		value_pool[0] = 0;
		value_pool[1] = -1;
		value_pool[2] = 42;
		value_pool[3] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_insert_edges();
		test_search();
		test_delete();
		test_full_list();
		test_random();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("array_list_insert_delete_search: match");
		else
			$display("array_list_insert_delete_search: mismatch");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("array_list_insert_delete_search: mismatch");
		$finish;
	end

endmodule
